// File: hdl/pct_pkg.sv
// Shared types and codes for the prefix-count trie.
package pct_pkg;

  localparam logic       OP_INSERT      = 1'b0;
  localparam logic       OP_QUERY       = 1'b1;
  localparam logic       STAT_ANSWER    = 1'b0;
  localparam logic       STAT_POOL_FULL = 1'b1;
  localparam logic [6:0] LETTER_BASE    = 7'd97;
  localparam int         OUT_COUNT_W    = 16;

  typedef struct packed {
    logic       opcode;
    logic [6:0] character;
    logic       word_end;
  } in_item_t;

  typedef struct packed {
    logic                   status;
    logic [OUT_COUNT_W-1:0] prefix_count;
  } out_item_t;

endpackage

// File: hdl/pct_link_store.sv
// Child-link memory with one read port, one write port and a zeroing sweep after reset.
module pct_link_store #(
  parameter int DEPTH  = 2,
  parameter int DATA_W = 1,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              busy
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] clr_idx_r, clr_idx_nxt;
  logic              busy_r, busy_nxt;

  always_comb begin
    clr_idx_nxt = clr_idx_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      if (clr_idx_r == ADDR_W'(DEPTH - 1)) begin
        busy_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// File: hdl/prefix_count_trie.sv
// Prefix-count trie over lower-case words, node pool in synchronous memories.
//
//   channel | dir | payload    | handshake
//   in_     | in  | in_item_t  | in_valid / in_stall
//   out_    | out | out_item_t | out_valid / out_stall
//
// An item passes a link read, then a link/count update or its answer.
// An item reading an existing node's count: link read, count read, count write or answer.
// After reset all POOL_NODES*ALPHABET_SIZE link slots are zeroed;
// in_stall falls in the cycle after the sweep ends.
// A result waits in the output register; a new result holds the engine while it is stalled.
module prefix_count_trie #(
  parameter int POOL_NODES    = 4096,
  parameter int ALPHABET_SIZE = 26,
  parameter int COUNT_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pct_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pct_pkg::out_item_t  out_data
);
  import pct_pkg::*;

  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int FREE_W     = NODE_W + 1;
  localparam int LINK_DEPTH = POOL_NODES * ALPHABET_SIZE;
  localparam int SLOT_W     = $clog2(LINK_DEPTH);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LINK  = 2'd2;
  localparam logic [1:0] S_CNT   = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [NODE_W-1:0]     cursor_r, cursor_nxt;
  logic [FREE_W-1:0]     free_r, free_nxt;
  logic                  missed_r, missed_nxt;
  logic                  failed_r, failed_nxt;
  logic                  op_r, end_r, act_r, lok_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic [6:0]            letter;
  logic                  letter_ok, accept, act;
  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W-1:0]     slot_r;
  logic                  link_busy;
  logic [NODE_W-1:0]     child;
  logic                  link_we;
  logic                  out_free, emit;

  logic                  cnt_re, cnt_we;
  logic [NODE_W-1:0]     cnt_ra, cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd, cnt_rd_r, cnt_inc;
  logic [COUNT_BITS-1:0] cnt_mem [POOL_NODES];
  logic [31:0]           cnt_ext;

  assign letter    = in_data.character - LETTER_BASE;
  assign letter_ok = 32'(letter) < ALPHABET_SIZE;
  assign accept    = in_valid && !in_stall;
  assign act       = letter_ok && ((in_data.opcode == OP_INSERT) ? !failed_r : !missed_r);
  assign slot      = SLOT_W'(cursor_r) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(letter);
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign cnt_inc   = (cnt_rd_r == '1) ? cnt_rd_r : cnt_rd_r + COUNT_BITS'(1);
  assign cnt_ext   = 32'(cnt_rd_r);

  pct_link_store #(
    .DEPTH  (LINK_DEPTH),
    .DATA_W (NODE_W)
  ) u_links (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept && act),
    .rd_addr (slot),
    .rd_data (child),
    .wr_en   (link_we),
    .wr_addr (slot_r),
    .wr_data (free_r[NODE_W-1:0]),
    .busy    (link_busy)
  );

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    free_nxt      = free_r;
    missed_nxt    = missed_r;
    failed_nxt    = failed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    link_we       = 1'b0;
    cnt_re        = 1'b0;
    cnt_ra        = child;
    cnt_we        = 1'b0;
    cnt_wa        = cursor_r;
    cnt_wd        = cnt_inc;
    emit          = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (!link_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LINK;
        end
      end
      S_LINK: begin
        // resolve the child link of this beat
        if (op_r == OP_INSERT) begin
          if (act_r) begin
            if (child == '0) begin
              if (free_r >= FREE_W'(POOL_NODES)) begin
                failed_nxt = 1'b1;
              end else begin
                link_we    = 1'b1;
                cnt_we     = 1'b1;
                cnt_wa     = free_r[NODE_W-1:0];
                cnt_wd     = COUNT_BITS'(1);
                cursor_nxt = free_r[NODE_W-1:0];
                free_nxt   = free_r + FREE_W'(1);
              end
            end else begin
              cursor_nxt = child;
            end
          end
        end else begin
          if (act_r) begin
            if (child == '0) begin
              missed_nxt = 1'b1;
            end else begin
              cursor_nxt = child;
            end
          end else if (!lok_r) begin
            missed_nxt = 1'b1;
          end
        end
        if (op_r == OP_INSERT && act_r && child != '0) begin
          cnt_re    = 1'b1;
          state_nxt = S_CNT;
        end else if (end_r && op_r == OP_QUERY && !missed_nxt) begin
          cnt_re    = 1'b1;
          state_nxt = S_CNT;
        end else if (end_r) begin
          emit = (op_r == OP_QUERY) || failed_nxt;
          out_data_nxt.status       = (op_r == OP_QUERY) ? STAT_ANSWER : STAT_POOL_FULL;
          out_data_nxt.prefix_count = '0;
          cursor_nxt = '0;
          missed_nxt = 1'b0;
          failed_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_IDLE;
        end
        // hold everything while a new result cannot be placed
        if (emit && !out_free) begin
          state_nxt    = state_r;
          cursor_nxt   = cursor_r;
          free_nxt     = free_r;
          missed_nxt   = missed_r;
          failed_nxt   = failed_r;
          out_data_nxt = out_data_r;
          link_we      = 1'b0;
          cnt_we       = 1'b0;
          cnt_re       = 1'b0;
          emit         = 1'b0;
        end
      end
      S_CNT: begin
        if (op_r == OP_INSERT) begin
          cnt_we = 1'b1;
        end
        if (end_r) begin
          emit = (op_r == OP_QUERY);
          out_data_nxt.status       = STAT_ANSWER;
          out_data_nxt.prefix_count = cnt_ext[OUT_COUNT_W-1:0];
          cursor_nxt = '0;
          missed_nxt = 1'b0;
          failed_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
        if (emit && !out_free) begin
          state_nxt    = state_r;
          cursor_nxt   = cursor_r;
          missed_nxt   = missed_r;
          failed_nxt   = failed_r;
          out_data_nxt = out_data_r;
          cnt_we       = 1'b0;
          emit         = 1'b0;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_data_nxt = out_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cursor_r    <= '0;
      free_r      <= FREE_W'(1);
      missed_r    <= 1'b0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      free_r      <= free_nxt;
      missed_r    <= missed_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      op_r   <= in_data.opcode;
      end_r  <= in_data.word_end;
      act_r  <= act;
      lok_r  <= letter_ok;
      slot_r <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_r <= cnt_mem[cnt_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/pct_chk.sv
// Port-level checks for the prefix-count trie, bound to the top level.
module pct_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input pct_pkg::out_item_t out_data
);
  import pct_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_one_beat_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input beat accepted while previous beat in flight");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_POOL_FULL |-> out_data.prefix_count == '0)
    else $error("pool-full result carries a count");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without engine activity");

endmodule

bind prefix_count_trie pct_chk u_pct_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
